/* src/nfa_pkg.sv */
package nfa_pkg;

    // Fixed field widths
    localparam int ADDR_W = 10;
    localparam int CNT_W  = 11;
    localparam int CFG_W  = 4;

    // Default tree depth limit and depth after reset
    localparam int MAX_ADDR_BITS_DEF = 10;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_DOUBLE = 2'd2;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  used_count;
    } t_out_word;

endpackage

/* src/nfa_ram.sv */
module nfa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/next_free_address_allocator_top.sv */
// Channel   Valid        Stall        Word
// input     i_in_valid   o_in_stall   i_in_word  (op, address)
// output    o_out_valid  i_out_stall  o_out_word (status, granted_address, used_count)
// config    i_cfg_we     -            i_cfg_data (address_bits)
//
// One word at a time. After a word is taken, the sequencer reads its leaf; an
// allocation of a full leaf climbs to a free sibling and descends to a free
// leaf, then the leaf is marked and the flags are refreshed level by level on
// the way up to the root before the word is done.
// The flag memory has one read port and one write port.
// After reset and after every config write a clearing pass zeroes all
// 2^(MAX_ADDR_BITS+1) flags; input is stalled meanwhile.
// A finished word waits in the output register while the next is taken.
module next_free_address_allocator_top #(
    parameter int MAX_ADDR_BITS = nfa_pkg::MAX_ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nfa_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nfa_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_we,
    input  logic [nfa_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int NW    = MAX_ADDR_BITS + 1;       // node index width
    localparam int DEPTH = 2 << MAX_ADDR_BITS;
    localparam int DW    = $clog2(MAX_ADDR_BITS + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LEAF, S_CLIMB, S_CLIMB_CHK,
        S_DESC, S_DESC_CHK, S_MARK, S_UP, S_UP_CHK, S_DONE
    } t_state;

    t_state                     r_state;
    logic [NW-1:0]              r_clr;
    logic [NW-1:0]              r_node;
    logic                       r_val;
    logic                       r_op;
    logic [nfa_pkg::ADDR_W-1:0] r_echo;
    logic [1:0]                 r_status;
    logic [nfa_pkg::CFG_W-1:0]  r_addr_bits;
    logic [NW-1:0]              r_used;
    logic                       r_out_valid;
    nfa_pkg::t_out_word         r_out_word;

    logic [DW-1:0]              w_depth;
    logic [NW-1:0]              w_leaf_base;
    logic [NW+nfa_pkg::ADDR_W-1:0] w_addr_ext;
    logic [NW-1:0]              w_in_node;
    logic [NW+nfa_pkg::ADDR_W-1:0] w_grant_ext;
    logic [NW+nfa_pkg::CNT_W-1:0]  w_cnt_ext;
    logic                       w_we;
    logic [NW-1:0]              w_waddr;
    logic                       w_wdata;
    logic [NW-1:0]              w_raddr;
    logic                       w_rdata;
    logic                       w_load;

    // Effective depth, clamped to 1..MAX_ADDR_BITS
    always_comb begin
        if (r_addr_bits == '0) begin
            w_depth = DW'(1);
        end else if (32'(r_addr_bits) > MAX_ADDR_BITS) begin
            w_depth = DW'(MAX_ADDR_BITS);
        end else begin
            w_depth = DW'(r_addr_bits);
        end
    end

    assign w_leaf_base = NW'(1) << w_depth;
    assign w_addr_ext  = {NW'(0), i_in_word.address};
    assign w_in_node   = w_leaf_base | (w_addr_ext[NW-1:0] & (w_leaf_base - NW'(1)));
    assign w_grant_ext = {nfa_pkg::ADDR_W'(0), r_node - w_leaf_base};
    assign w_cnt_ext   = {nfa_pkg::CNT_W'(0), r_used};

    // Finished word moves into the output register when it is free or taken
    assign w_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Flag memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_node;
        w_wdata = r_val;
        w_raddr = r_node;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 1'b0;
            end
            S_IDLE:   w_raddr = w_in_node;
            S_MARK:   w_we = 1'b1;
            S_CLIMB:  w_raddr = r_node + NW'(1);
            S_DESC:   w_raddr = {r_node[NW-2:0], 1'b0};
            S_UP:     w_raddr = r_node ^ NW'(1);
            S_UP_CHK: begin
                w_we    = 1'b1;
                w_waddr = r_node >> 1;
                w_wdata = r_val & w_rdata;
            end
            default: ;
        endcase
    end

    nfa_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_flags (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Sequencer: leaf check, climb, descend, mark, refresh path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_addr_bits <= nfa_pkg::CFG_RESET;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output register: load a finished word, drop it once taken
            if (w_load) begin
                r_out_valid                <= 1'b1;
                r_out_word.status          <= r_status;
                r_out_word.granted_address <= r_echo;
                r_out_word.used_count      <= w_cnt_ext[nfa_pkg::CNT_W-1:0];
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                // Depth change restarts with an empty tree
                r_addr_bits <= i_cfg_data;
                r_used      <= '0;
                r_clr       <= '0;
                r_state     <= S_CLEAR;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + NW'(1);
                        if (r_clr == '1) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_node   <= w_in_node;
                            r_op     <= i_in_word.op;
                            r_echo   <= i_in_word.address;
                            r_status <= nfa_pkg::ST_OK;
                            r_state  <= S_LEAF;
                        end
                    end
                    S_LEAF: begin
                        r_val <= (r_op == nfa_pkg::OP_ALLOC);
                        if (r_op == nfa_pkg::OP_ALLOC) begin
                            r_state <= w_rdata ? S_CLIMB : S_MARK;
                        end else if (!w_rdata) begin
                            r_status <= nfa_pkg::ST_DOUBLE;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_MARK;
                        end
                    end
                    S_CLIMB: begin
                        if (r_node <= NW'(1)) begin
                            r_status <= nfa_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else if (!r_node[0]) begin
                            r_state <= S_CLIMB_CHK;
                        end else begin
                            r_node <= r_node >> 1;
                        end
                    end
                    S_CLIMB_CHK: begin
                        if (!w_rdata) begin
                            r_node  <= r_node + NW'(1);
                            r_state <= S_DESC;
                        end else begin
                            r_node  <= r_node >> 1;
                            r_state <= S_CLIMB;
                        end
                    end
                    S_DESC: begin
                        if (r_node >= w_leaf_base) begin
                            r_state <= S_MARK;
                        end else begin
                            r_node  <= {r_node[NW-2:0], 1'b0};
                            r_state <= S_DESC_CHK;
                        end
                    end
                    S_DESC_CHK: begin
                        if (w_rdata) begin
                            r_node <= r_node + NW'(1);
                        end
                        r_state <= S_DESC;
                    end
                    S_MARK: begin
                        if (r_op == nfa_pkg::OP_ALLOC) begin
                            r_used <= r_used + NW'(1);
                            r_echo <= w_grant_ext[nfa_pkg::ADDR_W-1:0];
                        end else if (r_used != '0) begin
                            r_used <= r_used - NW'(1);
                        end
                        r_state <= S_UP;
                    end
                    S_UP: begin
                        r_state <= (r_node <= NW'(1)) ? S_DONE : S_UP_CHK;
                    end
                    S_UP_CHK: begin
                        r_val   <= r_val & w_rdata;
                        r_node  <= r_node >> 1;
                        r_state <= S_UP;
                    end
                    S_DONE: begin
                        if (w_load) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_CLEAR;
                endcase
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* src/nfa_checker.sv */
module nfa_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      i_cfg_we
);

    // Output word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // Nothing comes out right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An accepted word keeps the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // A depth write starts a clearing pass
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("input open right after config write");

endmodule

bind next_free_address_allocator_top nfa_checker u_nfa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_cfg_we   (i_cfg_we)
);

/* bench/tb_top.sv */
module tb_top;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    nfa_pkg::t_in_word           i_in_word;
    logic                        o_out_valid;
    logic                        i_out_stall;
    nfa_pkg::t_out_word          o_out_word;
    logic                        i_cfg_we;
    logic [nfa_pkg::CFG_W-1:0]   i_cfg_data;

    next_free_address_allocator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // allocator shadow state
    bit                  full_flag [0:2047];
    int unsigned         used_shadow;
    int unsigned         depth_shadow;
    nfa_pkg::t_out_word  pending_words [$];
    int                  errors;
    int                  send_idle_pct;
    int                  stall_pct;

    function automatic void clear_tree();
        foreach (full_flag[i]) full_flag[i] = 1'b0;
        used_shadow = 0;
    endfunction

    function automatic void set_depth(logic [nfa_pkg::CFG_W-1:0] v);
        depth_shadow = (v < 1) ? 1 : ((v > 10) ? 10 : v);
        clear_tree();
    endfunction

    // walk the flag tree up to the root
    function automatic void refresh_path(int unsigned n);
        while (n > 1) begin
            n = n >> 1;
            full_flag[n] = full_flag[2*n] & full_flag[2*n+1];
        end
    endfunction

    // next free address prediction
    function automatic nfa_pkg::t_out_word predict_alloc(nfa_pkg::t_in_word w);
        nfa_pkg::t_out_word r;
        int unsigned base;
        int unsigned n;
        bit          found;
        base = 1 << depth_shadow;
        n = base | (w.address & (base - 1));
        r.status = nfa_pkg::ST_OK;
        r.granted_address = w.address;
        found = 1'b0;
        if (w.op == nfa_pkg::OP_ALLOC) begin
            if (!full_flag[n]) found = 1'b1;
            else begin
                while (n > 1 && !found) begin
                    if ((n & 1) == 0 && !full_flag[n+1]) begin
                        n = n + 1;
                        found = 1'b1;
                    end else n = n >> 1;
                end
                if (found)
                    while (n < base) begin
                        n = 2 * n;
                        if (full_flag[n]) n = n + 1;
                    end
            end
            if (found) begin
                full_flag[n] = 1'b1;
                refresh_path(n);
                used_shadow++;
                r.granted_address = nfa_pkg::ADDR_W'(n - base);
            end else r.status = nfa_pkg::ST_FULL;
        end else begin
            if (!full_flag[n]) r.status = nfa_pkg::ST_DOUBLE;
            else begin
                full_flag[n] = 1'b0;
                refresh_path(n);
                if (used_shadow > 0) used_shadow--;
            end
        end
        r.used_count = nfa_pkg::CNT_W'(used_shadow);
        return r;
    endfunction

    // send one word, predicting at acceptance; valid stays up for the next word
    task automatic send_word(logic op, logic [nfa_pkg::ADDR_W-1:0] addr);
        nfa_pkg::t_in_word w;
        w.op = op;
        w.address = addr;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        pending_words.push_back(predict_alloc(w));
    endtask

    // receiver stall
    always @(posedge i_clk)
        i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_out_word);
                errors++;
            end else begin
                nfa_pkg::t_out_word e;
                e = pending_words.pop_front();
                if (e.status !== o_out_word.status)
                    $display("%0t: status exp %0d got %0d", $time, e.status,
                             o_out_word.status);
                if (e.granted_address !== o_out_word.granted_address)
                    $display("%0t: address exp %0d got %0d", $time,
                             e.granted_address, o_out_word.granted_address);
                if (e.used_count !== o_out_word.used_count)
                    $display("%0t: count exp %0d got %0d", $time, e.used_count,
                             o_out_word.used_count);
                if (e !== o_out_word) errors++;
            end
        end
    end

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // write depth while idle; clearing pass stalls input afterwards
    task automatic write_depth(logic [nfa_pkg::CFG_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        set_depth(v);
        i_cfg_we <= 1'b0;
    endtask

    // extremes, every op, double free, full tree
    task automatic test_directed();
        send_word(nfa_pkg::OP_ALLOC, 10'd0);
        send_word(nfa_pkg::OP_ALLOC, 10'd0);
        send_word(nfa_pkg::OP_ALLOC, 10'd1023);
        send_word(nfa_pkg::OP_ALLOC, 10'd1023);
        send_word(nfa_pkg::OP_FREE, 10'd1023);
        send_word(nfa_pkg::OP_FREE, 10'd1023);
        send_word(nfa_pkg::OP_FREE, 10'd0);
        send_word(nfa_pkg::OP_FREE, 10'h2AA);
        send_word(nfa_pkg::OP_ALLOC, 10'h155);
        write_depth(4'd0);
        send_word(nfa_pkg::OP_ALLOC, 10'h3FF);
        send_word(nfa_pkg::OP_ALLOC, 10'd0);
        send_word(nfa_pkg::OP_ALLOC, 10'd0);
        send_word(nfa_pkg::OP_ALLOC, 10'd0);
        send_word(nfa_pkg::OP_FREE, 10'd2);
        send_word(nfa_pkg::OP_FREE, 10'd1);
        send_word(nfa_pkg::OP_ALLOC, 10'd0);
        write_depth(4'd15);
        send_word(nfa_pkg::OP_ALLOC, 10'd512);
        write_depth(4'd2);
        repeat (5) send_word(nfa_pkg::OP_ALLOC, 10'd1);
    endtask

    // mostly allocate at random addresses, with frees biased toward low addresses
    task automatic test_random(int count, logic [nfa_pkg::CFG_W-1:0] depth);
        logic [nfa_pkg::ADDR_W-1:0] a;
        write_depth(depth);
        for (int i = 0; i < count; i++) begin
            a = nfa_pkg::ADDR_W'($urandom);
            if ($urandom_range(99) < 55) send_word(nfa_pkg::OP_ALLOC, a);
            else send_word(nfa_pkg::OP_FREE,
                           nfa_pkg::ADDR_W'(a & ((1 << depth_shadow) - 1) & $urandom));
        end
    endtask

    task automatic test_idling();
        int plan [4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{31, 31}};
        logic [nfa_pkg::CFG_W-1:0] depths [4] = '{4'd10, 4'd3, 4'd1, 4'd6};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = plan[p][0];
            stall_pct     = plan[p][1];
            test_random(200, depths[p]);
            test_random(230, nfa_pkg::CFG_W'($urandom_range(15)));
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = nfa_pkg::CFG_RESET;
        set_depth(nfa_pkg::CFG_RESET);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_idling();
        drain();
        if (errors == 0)
            $display("** next_free_address_allocator_top: PASSED **");
        else
            $display("** next_free_address_allocator_top: FAILED **");
        $finish;
    end

    // timeout
    initial begin
        #2000000;
        $display("** next_free_address_allocator_top: FAILED **");
        $finish;
    end
endmodule
